[rtl/multi_policy_cpu_scheduler_macros.svh]
// Assertion macros used by the scheduler top-level RTL.
`ifndef MULTI_POLICY_CPU_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_CPU_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define MSCHED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSCHED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSCHED_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSCHED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/msched_pkg.sv]
package msched_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned FB_LEVELS     = 3;
  localparam int unsigned TIME_BITS     = 16;
  localparam int unsigned LEVEL_BITS    = 3;
  localparam int unsigned QUSED_BITS    = 10;
  localparam int unsigned CFG_IDX_BITS  = 2;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    MODE_FCFS      = 3'd0,
    MODE_RR        = 3'd1,
    MODE_SPN       = 3'd2,
    MODE_SRT       = 3'd3,
    MODE_HRRN      = 3'd4,
    MODE_FB_FIXED  = 3'd5,
    MODE_FB_DOUBLE = 3'd6,
    MODE_AGING     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    RES_ACCEPT = 2'd0,
    RES_REJECT = 2'd1,
    RES_IDLE   = 2'd2,
    RES_RAN    = 2'd3
  } res_kind_e;

  typedef enum logic {
    REQ_ARRIVE = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POLICY_MODE  = 2'd0,
    CFG_TIME_QUANTUM = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_APPEND  = 2'd1,
    CELL_PREPEND = 2'd2,
    CELL_REMOVE  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [7:0]            task_id;
    logic [15:0]           burst;
    logic [15:0]           remaining;
    time_t                 arrival;
    logic [7:0]            prio;
    logic [LEVEL_BITS-1:0] level;
    logic                  in_fb;
  } task_t;

  typedef struct packed {
    cell_op_e op;
    logic     age;
  } cell_ctrl_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [15:0] tick_time;
    logic [7:0]  running_id;
    logic        task_finished;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] wait_total;
    logic        first_run;
    logic [15:0] response_delay;
  } res_t;

endpackage

[rtl/msched_if.sv]
interface msched_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  task_id;
  logic [15:0] burst_length;
  logic [7:0]  base_priority;
  modport source (output valid, req_type, task_id, burst_length, base_priority,
                  input ready);
  modport sink (input valid, req_type, task_id, burst_length, base_priority,
                output ready);
endinterface

interface msched_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] tick_time;
  logic [7:0]  running_id;
  logic        task_finished;
  logic [15:0] finish_time;
  logic [15:0] turnaround;
  logic [15:0] wait_total;
  logic        first_run;
  logic [15:0] response_delay;
  modport source (output valid, result_kind, tick_time, running_id, task_finished,
                  finish_time, turnaround, wait_total, first_run, response_delay,
                  input ready);
  modport sink (input valid, result_kind, tick_time, running_id, task_finished,
                finish_time, turnaround, wait_total, first_run, response_delay,
                output ready);
endinterface

interface msched_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/msched_cell.sv]
module msched_cell #(
  parameter int unsigned MAX_TASKS = msched_pkg::MAX_TASKS_DEF,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msched_pkg::cell_ctrl_t       ctrl_i,
  input  logic [$clog2(MAX_TASKS)-1:0] remove_idx_i,
  input  msched_pkg::task_t            new_task_i,
  input  logic                         prev_valid_i,
  input  msched_pkg::task_t            prev_task_i,
  input  logic                         next_valid_i,
  input  msched_pkg::task_t            next_task_i,
  output logic                         valid_o,
  output msched_pkg::task_t            task_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);

  logic              valid_q, valid_d;
  msched_pkg::task_t task_q, task_d;

  always_comb begin
    valid_d = valid_q;
    task_d  = task_q;
    unique case (ctrl_i.op)
      msched_pkg::CELL_APPEND: begin
        if (!valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          task_d  = new_task_i;
        end
      end
      msched_pkg::CELL_PREPEND: begin
        valid_d = prev_valid_i;
        task_d  = prev_task_i;
      end
      msched_pkg::CELL_REMOVE: begin
        if (IW'(CELL_IDX) >= remove_idx_i) begin
          valid_d = next_valid_i;
          task_d  = next_task_i;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
    if (ctrl_i.age && valid_d && !task_d.in_fb && task_d.prio != 8'hFF) begin
      task_d.prio = task_d.prio + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
  end

  assign valid_o = valid_q;
  assign task_o  = task_q;

endmodule

[rtl/multi_policy_cpu_scheduler.sv]
// Arrival: ARRIVE, then EMIT, which registers the result; the next request is taken after EMIT.
// Tick: PREP, a one-cell-per-cycle SCAN over the task cell row, then TAKE, EXEC and EMIT
//   when the scan picks a task; TAKE goes straight to EMIT on an idle tick, and PREP goes
//   to EXEC and EMIT with no scan when the running task keeps the processor.
// A result held by the receiver holds off the next transaction.
// Reset: task row empty, no running task, tick 0, mode FCFS, quantum 1; no clearing pass.
`include "multi_policy_cpu_scheduler_macros.svh"
module multi_policy_cpu_scheduler #(
  parameter int unsigned MAX_TASKS = msched_pkg::MAX_TASKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msched_req_if.sink  req_i,
  msched_res_if.source res_o,
  msched_cfg_if.sink  cfg_i
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned TW = msched_pkg::TIME_BITS;
  localparam int unsigned WW = (TW > 16) ? TW : 16;
  localparam int unsigned SW = WW + 1;
  localparam int unsigned LB = msched_pkg::LEVEL_BITS;
  localparam int unsigned QB = msched_pkg::QUSED_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ARRIVE = 7'b0000010,
    ST_PREP   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_TAKE   = 7'b0010000,
    ST_EXEC   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  msched_pkg::mode_e     mode_q;
  logic [7:0]            quantum_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  cur_valid_q, cur_valid_d;
  msched_pkg::task_t     cur_q, cur_d;
  logic [QB-1:0]         qused_q, qused_d;
  msched_pkg::time_t     now_q, now_d;
  logic [IW-1:0]         scan_idx_q, scan_idx_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic                  best_found_q, best_found_d;
  msched_pkg::task_t     best_q, best_d;
  logic [7:0]            req_id_q;
  logic [15:0]           req_burst_q;
  logic [7:0]            req_prio_q;
  msched_pkg::res_t      res_q, res_d;
  msched_pkg::res_t      out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  msched_pkg::cell_ctrl_t cell_ctrl;
  logic [IW-1:0]          remove_idx;
  msched_pkg::task_t      new_task;
  logic [MAX_TASKS-1:0]   cell_valid;
  msched_pkg::task_t      cell_task [MAX_TASKS];

  logic req_fire;
  logic fb_mode;
  logic higher;
  logic better;
  logic full;
  msched_pkg::task_t cand;
  logic              cand_match;

  logic [7:0]        q_eff;
  logic [14:0]       lim_wide;
  logic [QB-1:0]     fb_lim;
  logic [LB-1:0]     next_lvl;
  msched_pkg::time_t wait_a, wait_b;
  logic [SW-1:0]     sum_a, sum_b;
  logic [SW+15:0]    prod_lhs, prod_rhs;

  msched_pkg::time_t resp, fin, ta;
  logic [15:0]       rem_n;
  logic [WW-1:0]     ta_w, burst_w, wt_w;
  msched_pkg::time_t now_inc;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign fb_mode     = (mode_q == msched_pkg::MODE_FB_FIXED) ||
                       (mode_q == msched_pkg::MODE_FB_DOUBLE);
  assign full        = ((CW+1)'(cnt_q) + (CW+1)'(cur_valid_q)) == (CW+1)'(MAX_TASKS);
  assign now_inc     = (now_q != '1) ? now_q + 1'b1 : now_q;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic              prev_valid, next_valid;
    msched_pkg::task_t prev_task, next_task;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign prev_task  = new_task;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
      assign prev_task  = cell_task[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_task  = cell_task[i];
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_task  = cell_task[i+1];
    end
    msched_cell #(
      .MAX_TASKS (MAX_TASKS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .remove_idx_i (remove_idx),
      .new_task_i   (new_task),
      .prev_valid_i (prev_valid),
      .prev_task_i  (prev_task),
      .next_valid_i (next_valid),
      .next_task_i  (next_task),
      .valid_o      (cell_valid[i]),
      .task_o       (cell_task[i])
    );
  end

  always_comb begin
    higher = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (cell_valid[i] && cell_task[i].in_fb && cell_task[i].level < cur_q.level) begin
        higher = 1'b1;
      end
    end
  end

  always_comb begin
    q_eff    = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
    lim_wide = (mode_q == msched_pkg::MODE_FB_DOUBLE) ? (15'(q_eff) << cur_q.level)
                                                     : 15'(q_eff);
    fb_lim   = (lim_wide > 15'(2**QB - 1)) ? '1 : lim_wide[QB-1:0];
    next_lvl = (cur_q.level < LB'(msched_pkg::FB_LEVELS - 1)) ? cur_q.level + 1'b1
                                                              : cur_q.level;
  end

  always_comb begin
    cand       = cell_task[scan_idx_q];
    cand_match = cell_valid[scan_idx_q] && (cand.in_fb == fb_mode);
    wait_a     = now_q - cand.arrival;
    wait_b     = now_q - best_q.arrival;
    sum_a      = SW'(wait_a) + SW'(cand.burst);
    sum_b      = SW'(wait_b) + SW'(best_q.burst);
    prod_lhs   = (SW+16)'(sum_b) * (SW+16)'(cand.burst);
    prod_rhs   = (SW+16)'(sum_a) * (SW+16)'(best_q.burst);
    unique case (mode_q)
      msched_pkg::MODE_SPN:  better = cand.burst < best_q.burst;
      msched_pkg::MODE_SRT:  better = cand.remaining < best_q.remaining;
      msched_pkg::MODE_HRRN: better = prod_lhs < prod_rhs;
      msched_pkg::MODE_AGING: begin
        better = (cand.prio > best_q.prio) ||
                 ((cand.prio == best_q.prio) && (cand.arrival < best_q.arrival));
      end
      msched_pkg::MODE_FB_FIXED, msched_pkg::MODE_FB_DOUBLE: begin
        better = cand.level < best_q.level;
      end
      default: better = 1'b0;
    endcase
  end

  always_comb begin
    resp    = now_q - cur_q.arrival;
    rem_n   = cur_q.remaining - 16'd1;
    fin     = now_inc;
    ta      = fin - cur_q.arrival;
    ta_w    = WW'(ta);
    burst_w = WW'(cur_q.burst);
    wt_w    = (ta_w >= burst_w) ? ta_w - burst_w : '0;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    qused_d      = qused_q;
    now_d        = now_q;
    scan_idx_d   = scan_idx_q;
    best_idx_d   = best_idx_q;
    best_found_d = best_found_q;
    best_d       = best_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    cell_ctrl    = '{op: msched_pkg::CELL_HOLD, age: 1'b0};
    remove_idx   = best_idx_q;
    new_task     = cur_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.req_type == msched_pkg::REQ_TICK) ? ST_PREP : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        res_d           = '0;
        res_d.tick_time = 16'(now_q);
        if (full) begin
          res_d.kind = msched_pkg::RES_REJECT;
        end else begin
          res_d.kind         = msched_pkg::RES_ACCEPT;
          new_task.task_id   = req_id_q;
          new_task.burst     = (req_burst_q == 16'd0) ? 16'd1 : req_burst_q;
          new_task.remaining = new_task.burst;
          new_task.arrival   = now_q;
          new_task.prio      = req_prio_q;
          new_task.level     = '0;
          new_task.in_fb     = fb_mode;
          cell_ctrl.op       = msched_pkg::CELL_APPEND;
          cnt_d              = cnt_q + 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_PREP: begin
        scan_idx_d   = '0;
        best_found_d = 1'b0;
        state_d      = ST_SCAN;
        if (cur_valid_q) begin
          unique case (mode_q)
            msched_pkg::MODE_FCFS, msched_pkg::MODE_SPN, msched_pkg::MODE_HRRN: begin
              state_d = ST_EXEC;
            end
            msched_pkg::MODE_RR: begin
              if (qused_q >= QB'(quantum_q)) begin
                new_task.in_fb = 1'b0;
                cell_ctrl.op   = msched_pkg::CELL_APPEND;
                cnt_d          = cnt_q + 1'b1;
                cur_valid_d    = 1'b0;
                qused_d        = '0;
              end else begin
                state_d = ST_EXEC;
              end
            end
            msched_pkg::MODE_SRT, msched_pkg::MODE_AGING: begin
              new_task.in_fb = 1'b0;
              cell_ctrl.op   = msched_pkg::CELL_APPEND;
              cnt_d          = cnt_q + 1'b1;
              cur_valid_d    = 1'b0;
            end
            default: begin
              new_task.in_fb = 1'b1;
              if (qused_q >= fb_lim) begin
                new_task.level = next_lvl;
                cell_ctrl.op   = msched_pkg::CELL_APPEND;
                cnt_d          = cnt_q + 1'b1;
                cur_valid_d    = 1'b0;
                qused_d        = '0;
              end else if (higher) begin
                cell_ctrl.op   = msched_pkg::CELL_PREPEND;
                cnt_d          = cnt_q + 1'b1;
                cur_valid_d    = 1'b0;
                qused_d        = '0;
              end else begin
                state_d = ST_EXEC;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cand_match && (!best_found_q || better)) begin
          best_d       = cand;
          best_idx_d   = scan_idx_q;
          best_found_d = 1'b1;
        end
        if (scan_idx_q == IW'(MAX_TASKS - 1)) begin
          state_d = ST_TAKE;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_TAKE: begin
        if (best_found_q) begin
          cell_ctrl.op  = msched_pkg::CELL_REMOVE;
          cell_ctrl.age = (mode_q == msched_pkg::MODE_AGING);
          cnt_d         = cnt_q - 1'b1;
          cur_d         = best_q;
          cur_valid_d   = 1'b1;
          if (mode_q == msched_pkg::MODE_RR || fb_mode) begin
            qused_d = '0;
          end
          state_d = ST_EXEC;
        end else begin
          res_d           = '0;
          res_d.kind      = msched_pkg::RES_IDLE;
          res_d.tick_time = 16'(now_q);
          now_d           = now_inc;
          state_d         = ST_EMIT;
        end
      end
      ST_EXEC: begin
        res_d            = '0;
        res_d.kind       = msched_pkg::RES_RAN;
        res_d.tick_time  = 16'(now_q);
        res_d.running_id = cur_q.task_id;
        if (cur_q.remaining == cur_q.burst) begin
          res_d.first_run      = 1'b1;
          res_d.response_delay = 16'(resp);
        end
        cur_d.remaining = rem_n;
        if (qused_q != '1) begin
          qused_d = qused_q + 1'b1;
        end
        if (rem_n == 16'd0) begin
          res_d.task_finished = 1'b1;
          res_d.finish_time   = 16'(fin);
          res_d.turnaround    = 16'(ta);
          res_d.wait_total    = 16'(wt_w);
          cur_valid_d         = 1'b0;
        end
        now_d   = now_inc;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= msched_pkg::MODE_FCFS;
      quantum_q    <= 8'd1;
      cnt_q        <= '0;
      cur_valid_q  <= 1'b0;
      qused_q      <= '0;
      now_q        <= '0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cur_valid_q  <= cur_valid_d;
      qused_q      <= qused_d;
      now_q        <= now_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == msched_pkg::CFG_POLICY_MODE) begin
          mode_q <= msched_pkg::mode_e'(cfg_i.data[2:0]);
        end else if (cfg_i.index == msched_pkg::CFG_TIME_QUANTUM) begin
          quantum_q <= cfg_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    scan_idx_q <= scan_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    out_q      <= out_d;
    if (req_fire) begin
      req_id_q    <= req_i.task_id;
      req_burst_q <= req_i.burst_length;
      req_prio_q  <= req_i.base_priority;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.result_kind    = out_q.kind;
  assign res_o.tick_time      = out_q.tick_time;
  assign res_o.running_id     = out_q.running_id;
  assign res_o.task_finished  = out_q.task_finished;
  assign res_o.finish_time    = out_q.finish_time;
  assign res_o.turnaround     = out_q.turnaround;
  assign res_o.wait_total     = out_q.wait_total;
  assign res_o.first_run      = out_q.first_run;
  assign res_o.response_delay = out_q.response_delay;

  `MSCHED_ASSERT(a_task_cap, clk_i, rst_ni, ((CW+1)'(cnt_q) + (CW+1)'(cur_valid_q)) <= (CW+1)'(MAX_TASKS), "task count exceeds capacity")
  `MSCHED_ASSERT(a_row_packed, clk_i, rst_ni, ((cell_valid & (cell_valid + 1'b1)) == '0) && ($countones(cell_valid) == int'(cnt_q)), "cell row not packed or count mismatch")
  `MSCHED_ASSERT(a_load_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "result loaded outside emit")
  `MSCHED_ASSERT_NEXT(a_tick_prep, clk_i, rst_ni, req_fire && (req_i.req_type == msched_pkg::REQ_TICK), state_q == ST_PREP, "tick transaction did not start selection")

endmodule

[sim/multi_policy_cpu_scheduler_test.sv]
`timescale 1ns / 1ps
module multi_policy_cpu_scheduler_test;

  localparam int NSLOT = 16;
  localparam int NLVL = 3;

  class sched_predictor;
    msched_pkg::mode_e  mode;
    logic [7:0]         quantum;
    bit                 used[NSLOT];
    logic [7:0]         tid[NSLOT];
    logic [15:0]        burst[NSLOT];
    logic [15:0]        remain[NSLOT];
    logic [15:0]        arrive[NSLOT];
    logic [7:0]         prio[NSLOT];
    logic [1:0]         level[NSLOT];
    int                 run_q[$];
    int                 lvl_q[NLVL][$];
    int                 cur;
    bit                 cur_valid;
    logic [9:0]         qused;
    logic [15:0]        now;
    msched_pkg::res_t   pending[$];
    int                 errors;

    function new();
      mode = msched_pkg::MODE_FCFS;
      quantum = 8'd1;
      foreach (used[i]) used[i] = 0;
      cur = 0;
      cur_valid = 0;
      qused = '0;
      now = '0;
      errors = 0;
    endfunction

    function void set_reg(msched_pkg::cfg_reg_e idx, logic [7:0] val);
      if (idx == msched_pkg::CFG_POLICY_MODE) mode = msched_pkg::mode_e'(val[2:0]);
      else quantum = val;
    endfunction

    function int unsigned fb_limit(int s);
      int unsigned q, lim;
      q = (quantum != 0) ? quantum : 1;
      lim = q;
      if (mode == msched_pkg::MODE_FB_DOUBLE) begin
        lim = q << level[s];
        if (lim > 1023) lim = 1023;
      end
      return lim;
    endfunction

    function void add_run(int s);
      if (run_q.size() < NSLOT) run_q = {run_q, s};
    endfunction

    function bit pick(output int sel);
      int best, a, b, lv;
      bit higher;
      longint unsigned wa, wb, sa, sb;
      sel = 0;
      case (mode)
        msched_pkg::MODE_FCFS, msched_pkg::MODE_SPN, msched_pkg::MODE_HRRN: begin
          if (cur_valid) begin
            sel = cur;
            return 1;
          end
          if (run_q.size() == 0) return 0;
          best = 0;
          for (int i = 1; i < run_q.size(); i++) begin
            a = run_q[i];
            b = run_q[best];
            if (mode == msched_pkg::MODE_SPN) begin
              if (burst[a] < burst[b]) best = i;
            end else if (mode == msched_pkg::MODE_HRRN) begin
              wa = now - arrive[a];
              wb = now - arrive[b];
              sa = burst[a];
              sb = burst[b];
              if ((wb + sb) * sa < (wa + sa) * sb) best = i;
            end
          end
          sel = run_q[best];
          run_q.delete(best);
          return 1;
        end
        msched_pkg::MODE_RR: begin
          if (cur_valid) begin
            if (qused >= quantum) begin
              add_run(cur);
              cur_valid = 0;
              qused = '0;
            end else begin
              sel = cur;
              return 1;
            end
          end
          if (run_q.size() == 0) return 0;
          sel = run_q[0];
          run_q.delete(0);
          qused = '0;
          return 1;
        end
        msched_pkg::MODE_SRT, msched_pkg::MODE_AGING: begin
          if (cur_valid) begin
            add_run(cur);
            cur_valid = 0;
          end
          if (run_q.size() == 0) return 0;
          best = 0;
          for (int i = 1; i < run_q.size(); i++) begin
            a = run_q[i];
            b = run_q[best];
            if (mode == msched_pkg::MODE_SRT) begin
              if (remain[a] < remain[b]) best = i;
            end else if (prio[a] > prio[b] ||
                         (prio[a] == prio[b] && arrive[a] < arrive[b])) begin
              best = i;
            end
          end
          sel = run_q[best];
          run_q.delete(best);
          if (mode == msched_pkg::MODE_AGING) begin
            foreach (run_q[i]) if (prio[run_q[i]] < 8'd255) prio[run_q[i]]++;
          end
          return 1;
        end
        default: begin
          if (cur_valid) begin
            lv = level[cur];
            if (qused >= fb_limit(cur)) begin
              if (lv < NLVL - 1) lv++;
              level[cur] = 2'(lv);
              if (lvl_q[lv].size() < NSLOT) lvl_q[lv] = {lvl_q[lv], cur};
              cur_valid = 0;
              qused = '0;
            end else begin
              higher = 0;
              for (int i = 0; i < lv; i++) if (lvl_q[i].size() != 0) higher = 1;
              if (higher) begin
                if (lvl_q[lv].size() < NSLOT) lvl_q[lv] = {cur, lvl_q[lv]};
                cur_valid = 0;
                qused = '0;
              end else begin
                sel = cur;
                return 1;
              end
            end
          end
          for (int i = 0; i < NLVL; i++) begin
            if (lvl_q[i].size() != 0) begin
              sel = lvl_q[i][0];
              lvl_q[i].delete(0);
              qused = '0;
              return 1;
            end
          end
          return 0;
        end
      endcase
    endfunction

    function void note_request(msched_pkg::req_e rt, logic [7:0] id, logic [15:0] bl,
                               logic [7:0] bp);
      msched_pkg::res_t r;
      int s;
      logic [15:0] fin, ta;
      r = '0;
      r.kind = msched_pkg::RES_ACCEPT;
      r.tick_time = now;
      if (rt == msched_pkg::REQ_ARRIVE) begin
        s = NSLOT;
        for (int i = NSLOT - 1; i >= 0; i--) if (!used[i]) s = i;
        if (s == NSLOT) begin
          r.kind = msched_pkg::RES_REJECT;
        end else begin
          used[s] = 1;
          tid[s] = id;
          burst[s] = (bl == 0) ? 16'd1 : bl;
          remain[s] = burst[s];
          arrive[s] = now;
          prio[s] = bp;
          level[s] = '0;
          if (mode == msched_pkg::MODE_FB_FIXED || mode == msched_pkg::MODE_FB_DOUBLE) begin
            if (lvl_q[0].size() < NSLOT) lvl_q[0] = {lvl_q[0], s};
          end else begin
            add_run(s);
          end
        end
      end else begin
        if (!pick(s)) begin
          cur_valid = 0;
          r.kind = msched_pkg::RES_IDLE;
        end else begin
          cur = s;
          cur_valid = 1;
          r.kind = msched_pkg::RES_RAN;
          r.running_id = tid[s];
          if (remain[s] == burst[s]) begin
            r.first_run = 1'b1;
            r.response_delay = now - arrive[s];
          end
          remain[s]--;
          if (qused < 10'd1023) qused++;
          if (remain[s] == 0) begin
            fin = (now < 16'hFFFF) ? now + 16'd1 : 16'hFFFF;
            ta = fin - arrive[s];
            r.task_finished = 1'b1;
            r.finish_time = fin;
            r.turnaround = ta;
            r.wait_total = (ta >= burst[s]) ? ta - burst[s] : 16'd0;
            used[s] = 0;
            cur_valid = 0;
          end
        end
        if (now < 16'hFFFF) now++;
      end
      pending = {pending, r};
    endfunction

    function void check_result(msched_pkg::res_t got);
      msched_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_stall;
  bit   hold_req;
  sched_predictor sched;

  msched_req_if req();
  msched_res_if res();
  msched_cfg_if cfg();

  multi_policy_cpu_scheduler u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .res_o (res),
    .cfg_i (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    msched_pkg::res_t got;
    forever begin
      @(negedge clk);
      if (rst_n && res.valid && res.ready) begin
        got.kind = msched_pkg::res_kind_e'(res.result_kind);
        got.tick_time = res.tick_time;
        got.running_id = res.running_id;
        got.task_finished = res.task_finished;
        got.finish_time = res.finish_time;
        got.turnaround = res.turnaround;
        got.wait_total = res.wait_total;
        got.first_run = res.first_run;
        got.response_delay = res.response_delay;
        @(posedge clk);
        sched.check_result(got);
      end
    end
  end

  task automatic send_item(msched_pkg::req_e rt, logic [7:0] id, logic [15:0] bl,
                           logic [7:0] bp);
    if ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req.valid <= 1'b1;
    req.req_type <= rt;
    req.task_id <= id;
    req.burst_length <= bl;
    req.base_priority <= bp;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    sched.note_request(rt, id, bl, bp);
  endtask

  task automatic drain;
    @(posedge clk);
    req.valid <= 1'b0;
    while (sched.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(msched_pkg::cfg_reg_e idx, logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    sched.set_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item;
    logic [15:0] bl;
    if ($urandom_range(99) < 38) begin
      if ($urandom_range(149) == 0) bl = 16'($urandom_range(65535));
      else bl = 16'($urandom_range(12));
      send_item(msched_pkg::REQ_ARRIVE, 8'($urandom_range(255)), bl,
                8'($urandom_range(255)));
    end else begin
      send_item(msched_pkg::REQ_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [7:0] qv;
    sched = new();
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    rst_n <= 1'b0;
    req.valid <= 1'b0;
    req.req_type <= msched_pkg::REQ_ARRIVE;
    req.task_id <= '0;
    req.burst_length <= '0;
    req.base_priority <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= msched_pkg::CFG_POLICY_MODE;
    cfg.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_item(msched_pkg::REQ_ARRIVE, 8'd0, 16'd0, 8'd0);
    send_item(msched_pkg::REQ_ARRIVE, 8'd255, 16'd1, 8'd255);
    send_item(msched_pkg::REQ_TICK, 8'd0, 16'd0, 8'd0);
    send_item(msched_pkg::REQ_ARRIVE, 8'd255, 16'd3, 8'd128);
    for (int i = 0; i < 15; i++) send_item(msched_pkg::REQ_ARRIVE, 8'(i + 1), 16'd2, 8'(i * 17));
    for (int i = 0; i < 6; i++) send_item(msched_pkg::REQ_TICK, 8'hFF, 16'hFFFF, 8'hFF);

    for (int seg = 0; seg < 16; seg++) begin
      drain();
      case ($urandom_range(5))
        0: qv = 8'd0;
        1: qv = 8'd1;
        2: qv = 8'd255;
        default: qv = 8'($urandom_range(1, 6));
      endcase
      write_reg(msched_pkg::CFG_TIME_QUANTUM, qv);
      write_reg(msched_pkg::CFG_POLICY_MODE, 8'(seg % 8));
      case (seg % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      if (seg == 4) hold_req = 1;
      for (int i = 0; i < 100; i++) random_item();
    end

    @(posedge clk);
    req.valid <= 1'b0;
    while (sched.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sched.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/msched_pkg.sv
rtl/msched_if.sv
rtl/msched_cell.sv
rtl/multi_policy_cpu_scheduler.sv
sim/multi_policy_cpu_scheduler_test.sv
